@@ rtl/bra_pkg.sv @@
// Shared types, codes and helper functions of the boot region allocator.
package bra_pkg;

  localparam logic [1:0] OP_RESERVE    = 2'd0;
  localparam logic [1:0] OP_ALLOC_UP   = 2'd1;
  localparam logic [1:0] OP_ALLOC_DOWN = 2'd2;
  localparam logic [1:0] OP_GAPS       = 2'd3;

  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_OOM  = 2'd1;
  localparam logic [1:0] ST_FULL = 2'd2;

  localparam logic [4:0] DP_NOP        = 5'd0;
  localparam logic [4:0] DP_LOAD       = 5'd1;
  localparam logic [4:0] DP_RSV_A      = 5'd2;
  localparam logic [4:0] DP_RSV_B      = 5'd3;
  localparam logic [4:0] DP_RSV_C      = 5'd4;
  localparam logic [4:0] DP_RSV_D      = 5'd5;
  localparam logic [4:0] DP_INS_RD     = 5'd6;
  localparam logic [4:0] DP_INS_SHIFT  = 5'd7;
  localparam logic [4:0] DP_INS_PUT    = 5'd8;
  localparam logic [4:0] DP_PUSH_RSV   = 5'd9;
  localparam logic [4:0] DP_PUSH_ALLOC = 5'd10;
  localparam logic [4:0] DP_PUSH_OOM   = 5'd11;
  localparam logic [4:0] DP_UP_A       = 5'd12;
  localparam logic [4:0] DP_UP_B       = 5'd13;
  localparam logic [4:0] DP_ALIGN      = 5'd14;
  localparam logic [4:0] DP_SCAN_INIT  = 5'd15;
  localparam logic [4:0] DP_IDX_INC    = 5'd16;
  localparam logic [4:0] DP_HIT_UP     = 5'd17;
  localparam logic [4:0] DP_HIT_DN     = 5'd18;
  localparam logic [4:0] DP_SET_PB     = 5'd19;
  localparam logic [4:0] DP_DN_A       = 5'd20;
  localparam logic [4:0] DP_DN_B       = 5'd21;
  localparam logic [4:0] DP_DN_C       = 5'd22;
  localparam logic [4:0] DP_G_INIT     = 5'd23;
  localparam logic [4:0] DP_G_SKIP     = 5'd24;
  localparam logic [4:0] DP_G_NEW      = 5'd25;
  localparam logic [4:0] DP_G_EQ       = 5'd26;
  localparam logic [4:0] DP_G_TAIL     = 5'd27;
  localparam logic [4:0] DP_G_FIN      = 5'd28;

  typedef struct packed {
    logic [4:0] op;
  } dp_cmd_t;

  typedef struct packed {
    logic [1:0] opc;
    logic       rem_busy;
    logic       pg_ovf;
    logic       align_ovf;
    logic       fit_bad;
    logic       scan_end;
    logic       overlap;
    logic       iter_last;
    logic       hit_low;
    logic       size_gt_c;
    logic       c_lt_base;
    logic       full;
    logic       idx_zero;
    logic       ins_gt;
    logic       out_free;
    logic       gap_lt;
    logic       gap_gt;
    logic       pos_lt_end;
    logic       pend_v;
  } dp_stat_t;

  function automatic logic [63:0] sat_add(input logic [63:0] a, input logic [63:0] b);
    logic [64:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[64] ? '1 : s[63:0];
  endfunction

  // all bits at and below the highest set bit
  function automatic logic [63:0] smear(input logic [63:0] a);
    logic [63:0] m;
    m = a;
    m = m | (m >> 1);
    m = m | (m >> 2);
    m = m | (m >> 4);
    m = m | (m >> 8);
    m = m | (m >> 16);
    m = m | (m >> 32);
    return m;
  endfunction

endpackage

@@ rtl/bra_rem.sv @@
// Remainder of a 64-bit value by the page size, one 16-bit chunk at a time by reciprocal multiply.
module bra_rem #(
  parameter int PAGE_BYTES = 4096
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [63:0] x,
  output logic [$clog2(PAGE_BYTES+1)-1:0] rem,
  output logic        busy
);
  localparam int RW = $clog2(PAGE_BYTES + 1);
  localparam logic [32:0] RECIP = 33'((64'd1 << 32) / 64'(PAGE_BYTES));
  localparam logic [31:0] PB = 32'(PAGE_BYTES);

  logic [63:0] xs;
  logic [4:0]  cnt;
  logic [1:0]  ph;
  logic [31:0] v, q, t, qp;
  logic [63:0] prod;

  // per chunk: load v = rem:chunk, estimate quotient, subtract, one correction
  assign busy = (cnt != 5'd0);
  assign prod = 64'(v) * 64'(RECIP);
  assign qp   = q * PB;

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= 5'd0;
      ph  <= 2'd0;
    end else if (start) begin
      cnt <= 5'd16;
      ph  <= 2'd0;
    end else if (busy) begin
      cnt <= cnt - 5'd1;
      ph  <= ph + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      xs  <= x;
      rem <= '0;
    end else if (busy) begin
      unique case (ph)
        2'd0: begin
          v  <= {16'(rem), xs[63:48]};
          xs <= xs << 16;
        end
        2'd1: q <= prod[63:32];
        2'd2: t <= v - qp;
        default: begin
          if (t >= PB) begin
            rem <= RW'(t - PB);
          end else begin
            rem <= RW'(t);
          end
        end
      endcase
    end
  end
endmodule

@@ rtl/bra_dp.sv @@
// Datapath: region tables, working registers, output register and config registers.
module bra_dp #(
  parameter int MAX_REGIONS = 32,
  parameter int PAGE_BYTES  = 4096
) (
  input  logic               clk,
  input  logic               rst,
  input  bra_pkg::dp_cmd_t   cmd,
  output bra_pkg::dp_stat_t  stat,
  input  logic               cfg_valid,
  input  logic [0:0]         cfg_index,
  input  logic [63:0]        cfg_data,
  input  logic [191:0]       in_data,
  input  logic [1:0]         in_user,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [127:0]       out_data,
  output logic [1:0]         out_user,
  output logic               out_last
);
  import bra_pkg::*;

  localparam int IW  = $clog2(MAX_REGIONS);
  localparam int CW  = $clog2(MAX_REGIONS + 1);
  localparam int ITW = $clog2(MAX_REGIONS + 2);
  localparam int RW  = $clog2(PAGE_BYTES + 1);

  logic [63:0] st_mem [MAX_REGIONS];
  logic [63:0] ln_mem [MAX_REGIONS];

  logic [63:0] ram_base, ram_size;
  logic [1:0]  opc;
  logic [63:0] size, mask, wend, c, pb, rx, lo, hi, len, pos;
  logic [63:0] pend_addr, pend_size;
  logic        pend_v, full;
  logic [CW-1:0]  idx, count;
  logic [ITW-1:0] iter;
  logic [63:0] rd_start, rd_len;
  logic [63:0] out_addr, out_size;
  logic [1:0]  out_status;

  logic          rem_start, rem_busy;
  logic [63:0]   rem_x;
  logic [RW-1:0] rem;

  logic [63:0] rd_end, c_end, pgadd, pg_up_v, pg_dn, gap_end;
  logic        pg_ovf, out_free, we, out_push;
  logic [IW-1:0] raddr;
  logic [63:0] wd_start, wd_len;

  bra_rem #(.PAGE_BYTES(PAGE_BYTES)) u_rem (
    .clk(clk), .rst(rst), .start(rem_start), .x(rem_x), .rem(rem), .busy(rem_busy)
  );

  assign rd_end   = sat_add(rd_start, rd_len);
  assign c_end    = c + size;
  assign pgadd    = 64'(PAGE_BYTES) - 64'(rem);
  assign pg_ovf   = (rem != '0) && (rx > ~pgadd);
  assign pg_up_v  = (rem == '0) ? rx : (pg_ovf ? '1 : rx + pgadd);
  assign pg_dn    = rx - 64'(rem);
  assign gap_end  = (rd_start < wend) ? rd_start : wend;
  assign out_free = !out_valid || out_ready;
  assign out_push = (cmd.op == DP_PUSH_RSV) || (cmd.op == DP_PUSH_ALLOC) ||
                    (cmd.op == DP_PUSH_OOM) || (cmd.op == DP_G_FIN) ||
                    (((cmd.op == DP_G_NEW) || (cmd.op == DP_G_TAIL)) && pend_v);

  always_comb begin
    rem_start = 1'b0;
    rem_x     = pb;
    unique case (cmd.op)
      DP_RSV_A: rem_start = 1'b1;
      DP_RSV_B: begin
        rem_start = 1'b1;
        rem_x     = sat_add(pb, size);
      end
      DP_UP_A: begin
        rem_start = 1'b1;
        rem_x     = ram_base;
      end
      DP_DN_A: begin
        rem_start = 1'b1;
        rem_x     = wend;
      end
      default: rem_start = 1'b0;
    endcase
  end

  always_comb begin
    stat.opc        = opc;
    stat.rem_busy   = rem_busy;
    stat.pg_ovf     = pg_ovf;
    stat.align_ovf  = c > ~mask;
    stat.fit_bad    = (c > wend) || (size > wend - c);
    stat.scan_end   = idx >= count;
    stat.overlap    = (c < rd_end) && (c_end > rd_start);
    stat.iter_last  = iter == ITW'(MAX_REGIONS + 1);
    stat.hit_low    = rd_start < size;
    stat.size_gt_c  = size > c;
    stat.c_lt_base  = c < ram_base;
    stat.full       = full;
    stat.idx_zero   = idx == '0;
    stat.ins_gt     = rd_start > lo;
    stat.out_free   = out_free;
    stat.gap_lt     = rd_start < pos;
    stat.gap_gt     = rd_start > pos;
    stat.pos_lt_end = pos < wend;
    stat.pend_v     = pend_v;
  end

  assign raddr    = (cmd.op == DP_INS_RD) ? IW'(idx - CW'(1)) : idx[IW-1:0];
  assign we       = (cmd.op == DP_INS_SHIFT) || (cmd.op == DP_INS_PUT);
  assign wd_start = (cmd.op == DP_INS_SHIFT) ? rd_start : lo;
  assign wd_len   = (cmd.op == DP_INS_SHIFT) ? rd_len : len;

  always_ff @(posedge clk) begin
    rd_start <= st_mem[raddr];
    rd_len   <= ln_mem[raddr];
    if (we) begin
      st_mem[idx[IW-1:0]] <= wd_start;
      ln_mem[idx[IW-1:0]] <= wd_len;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ram_base <= '0;
      ram_size <= '0;
    end else if (cfg_valid) begin
      if (cfg_index == 1'b0) begin
        ram_base <= cfg_data;
      end else begin
        ram_size <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      idx       <= '0;
      iter      <= '0;
      full      <= 1'b0;
      pend_v    <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (out_ready && !out_push) begin
        out_valid <= 1'b0;
      end
      unique case (cmd.op)
        DP_LOAD: begin
          opc  <= in_user;
          pb   <= in_data[63:0];
          size <= in_data[127:64];
          mask <= smear(in_data[191:128]) >> 1;
          wend <= sat_add(ram_base, ram_size);
        end
        DP_RSV_A: rx <= pb;
        DP_RSV_B: begin
          lo <= pg_dn;
          rx <= sat_add(pb, size);
        end
        DP_RSV_C: hi <= pg_up_v;
        DP_RSV_D: begin
          len  <= hi - lo;
          idx  <= count;
          full <= count >= CW'(MAX_REGIONS);
        end
        DP_INS_SHIFT: idx <= idx - CW'(1);
        DP_INS_PUT:   count <= count + CW'(1);
        DP_PUSH_RSV: begin
          out_valid  <= 1'b1;
          out_addr   <= lo;
          out_size   <= len;
          out_status <= full ? ST_FULL : ST_OK;
          out_last   <= 1'b1;
        end
        DP_PUSH_ALLOC: begin
          out_valid  <= 1'b1;
          out_addr   <= c;
          out_size   <= size;
          out_status <= full ? ST_FULL : ST_OK;
          out_last   <= 1'b1;
        end
        DP_PUSH_OOM: begin
          out_valid  <= 1'b1;
          out_addr   <= '0;
          out_size   <= size;
          out_status <= ST_OOM;
          out_last   <= 1'b1;
        end
        DP_UP_A: rx <= ram_base;
        DP_UP_B: begin
          c    <= pg_up_v;
          iter <= '0;
        end
        DP_ALIGN:     c <= (c + mask) & ~mask;
        DP_SCAN_INIT: idx <= '0;
        DP_IDX_INC:   idx <= idx + CW'(1);
        DP_HIT_UP: begin
          c    <= rd_end;
          iter <= iter + ITW'(1);
        end
        DP_HIT_DN: begin
          c    <= (rd_start - size) & ~mask;
          iter <= iter + ITW'(1);
        end
        DP_SET_PB: pb <= c;
        DP_DN_A:   rx <= wend;
        DP_DN_B:   c <= pg_dn;
        DP_DN_C: begin
          c    <= (c - size) & ~mask;
          iter <= '0;
        end
        DP_G_INIT: begin
          pos    <= ram_base;
          idx    <= '0;
          pend_v <= 1'b0;
        end
        DP_G_SKIP: begin
          if (rd_end > pos) begin
            pos <= rd_end;
          end
          idx <= idx + CW'(1);
        end
        DP_G_NEW: begin
          if (pend_v) begin
            out_valid  <= 1'b1;
            out_addr   <= pend_addr;
            out_size   <= pend_size;
            out_status <= ST_OK;
            out_last   <= 1'b0;
          end
          pend_addr <= pos;
          pend_size <= gap_end - pos;
          pend_v    <= 1'b1;
          pos       <= rd_end;
          idx       <= idx + CW'(1);
        end
        DP_G_EQ: begin
          pos <= rd_end;
          idx <= idx + CW'(1);
        end
        DP_G_TAIL: begin
          if (pend_v) begin
            out_valid  <= 1'b1;
            out_addr   <= pend_addr;
            out_size   <= pend_size;
            out_status <= ST_OK;
            out_last   <= 1'b0;
          end
          pend_addr <= pos;
          pend_size <= wend - pos;
          pend_v    <= 1'b1;
          pos       <= wend;
        end
        DP_G_FIN: begin
          out_valid  <= 1'b1;
          out_addr   <= pend_v ? pend_addr : '0;
          out_size   <= pend_v ? pend_size : '0;
          out_status <= ST_OK;
          out_last   <= 1'b1;
          pend_v     <= 1'b0;
        end
        default: begin
        end
      endcase
    end
  end

  assign out_data = {out_size, out_addr};
  assign out_user = out_status;
endmodule

@@ rtl/bra_ctrl.sv @@
// Controller: sequences reserve, allocation and gap listing over the datapath.
module bra_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  bra_pkg::dp_stat_t stat,
  output bra_pkg::dp_cmd_t  cmd
);
  import bra_pkg::*;

  localparam logic [4:0] S_IDLE    = 5'd0;
  localparam logic [4:0] S_DISP    = 5'd1;
  localparam logic [4:0] S_RSV_A   = 5'd2;
  localparam logic [4:0] S_RSV_AW  = 5'd3;
  localparam logic [4:0] S_RSV_B   = 5'd4;
  localparam logic [4:0] S_RSV_BW  = 5'd5;
  localparam logic [4:0] S_RSV_C   = 5'd6;
  localparam logic [4:0] S_RSV_D   = 5'd7;
  localparam logic [4:0] S_INS_CHK = 5'd8;
  localparam logic [4:0] S_INS_RD  = 5'd9;
  localparam logic [4:0] S_INS_EV  = 5'd10;
  localparam logic [4:0] S_RES     = 5'd11;
  localparam logic [4:0] S_OOM     = 5'd12;
  localparam logic [4:0] S_UP_A    = 5'd13;
  localparam logic [4:0] S_UP_AW   = 5'd14;
  localparam logic [4:0] S_UP_B    = 5'd15;
  localparam logic [4:0] S_UP_CHK  = 5'd16;
  localparam logic [4:0] S_UP_FIT  = 5'd17;
  localparam logic [4:0] S_SC_CHK  = 5'd18;
  localparam logic [4:0] S_SC_RD   = 5'd19;
  localparam logic [4:0] S_SC_EV   = 5'd20;
  localparam logic [4:0] S_DN_A    = 5'd21;
  localparam logic [4:0] S_DN_AW   = 5'd22;
  localparam logic [4:0] S_DN_B    = 5'd23;
  localparam logic [4:0] S_DN_C    = 5'd24;
  localparam logic [4:0] S_DN_CHK  = 5'd25;
  localparam logic [4:0] S_G_INIT  = 5'd26;
  localparam logic [4:0] S_G_CHK   = 5'd27;
  localparam logic [4:0] S_G_RD    = 5'd28;
  localparam logic [4:0] S_G_EV    = 5'd29;
  localparam logic [4:0] S_G_TAIL  = 5'd30;
  localparam logic [4:0] S_G_FIN   = 5'd31;

  logic [4:0] state, state_next;

  assign in_ready = (state == S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd.op     = DP_NOP;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.op     = DP_LOAD;
          state_next = S_DISP;
        end
      end
      S_DISP: begin
        unique case (stat.opc)
          OP_RESERVE:    state_next = S_RSV_A;
          OP_ALLOC_UP:   state_next = S_UP_A;
          OP_ALLOC_DOWN: state_next = S_DN_A;
          default:       state_next = S_G_INIT;
        endcase
      end
      S_RSV_A: begin
        cmd.op     = DP_RSV_A;
        state_next = S_RSV_AW;
      end
      S_RSV_AW: if (!stat.rem_busy) state_next = S_RSV_B;
      S_RSV_B: begin
        cmd.op     = DP_RSV_B;
        state_next = S_RSV_BW;
      end
      S_RSV_BW: if (!stat.rem_busy) state_next = S_RSV_C;
      S_RSV_C: begin
        cmd.op     = DP_RSV_C;
        state_next = S_RSV_D;
      end
      S_RSV_D: begin
        cmd.op     = DP_RSV_D;
        state_next = S_INS_CHK;
      end
      S_INS_CHK: begin
        priority if (stat.full) begin
          state_next = S_RES;
        end else if (stat.idx_zero) begin
          cmd.op     = DP_INS_PUT;
          state_next = S_RES;
        end else begin
          state_next = S_INS_RD;
        end
      end
      S_INS_RD: begin
        cmd.op     = DP_INS_RD;
        state_next = S_INS_EV;
      end
      S_INS_EV: begin
        if (stat.ins_gt) begin
          cmd.op     = DP_INS_SHIFT;
          state_next = S_INS_CHK;
        end else begin
          cmd.op     = DP_INS_PUT;
          state_next = S_RES;
        end
      end
      S_RES: begin
        if (stat.out_free) begin
          cmd.op     = (stat.opc == OP_RESERVE) ? DP_PUSH_RSV : DP_PUSH_ALLOC;
          state_next = S_IDLE;
        end
      end
      S_OOM: begin
        if (stat.out_free) begin
          cmd.op     = DP_PUSH_OOM;
          state_next = S_IDLE;
        end
      end
      S_UP_A: begin
        cmd.op     = DP_UP_A;
        state_next = S_UP_AW;
      end
      S_UP_AW: if (!stat.rem_busy) state_next = S_UP_B;
      S_UP_B: begin
        if (stat.pg_ovf) begin
          state_next = S_OOM;
        end else begin
          cmd.op     = DP_UP_B;
          state_next = S_UP_CHK;
        end
      end
      S_UP_CHK: begin
        if (stat.align_ovf) begin
          state_next = S_OOM;
        end else begin
          cmd.op     = DP_ALIGN;
          state_next = S_UP_FIT;
        end
      end
      S_UP_FIT: begin
        if (stat.fit_bad) begin
          state_next = S_OOM;
        end else begin
          cmd.op     = DP_SCAN_INIT;
          state_next = S_SC_CHK;
        end
      end
      S_SC_CHK: begin
        if (stat.scan_end) begin
          cmd.op     = DP_SET_PB;
          state_next = S_RSV_A;
        end else begin
          state_next = S_SC_RD;
        end
      end
      S_SC_RD: state_next = S_SC_EV;
      S_SC_EV: begin
        priority if (!stat.overlap) begin
          cmd.op     = DP_IDX_INC;
          state_next = S_SC_CHK;
        end else if (stat.iter_last) begin
          state_next = S_OOM;
        end else if (stat.opc == OP_ALLOC_UP) begin
          cmd.op     = DP_HIT_UP;
          state_next = S_UP_CHK;
        end else if (stat.hit_low) begin
          state_next = S_OOM;
        end else begin
          cmd.op     = DP_HIT_DN;
          state_next = S_DN_CHK;
        end
      end
      S_DN_A: begin
        cmd.op     = DP_DN_A;
        state_next = S_DN_AW;
      end
      S_DN_AW: if (!stat.rem_busy) state_next = S_DN_B;
      S_DN_B: begin
        cmd.op     = DP_DN_B;
        state_next = S_DN_C;
      end
      S_DN_C: begin
        if (stat.size_gt_c) begin
          state_next = S_OOM;
        end else begin
          cmd.op     = DP_DN_C;
          state_next = S_DN_CHK;
        end
      end
      S_DN_CHK: begin
        if (stat.c_lt_base) begin
          state_next = S_OOM;
        end else begin
          cmd.op     = DP_SCAN_INIT;
          state_next = S_SC_CHK;
        end
      end
      S_G_INIT: begin
        cmd.op     = DP_G_INIT;
        state_next = S_G_CHK;
      end
      S_G_CHK: begin
        if (stat.scan_end || !stat.pos_lt_end) begin
          state_next = S_G_TAIL;
        end else begin
          state_next = S_G_RD;
        end
      end
      S_G_RD: state_next = S_G_EV;
      S_G_EV: begin
        priority if (stat.gap_lt) begin
          cmd.op     = DP_G_SKIP;
          state_next = S_G_CHK;
        end else if (stat.gap_gt) begin
          if (!stat.pend_v || stat.out_free) begin
            cmd.op     = DP_G_NEW;
            state_next = S_G_CHK;
          end
        end else begin
          cmd.op     = DP_G_EQ;
          state_next = S_G_CHK;
        end
      end
      S_G_TAIL: begin
        if (!stat.pos_lt_end) begin
          state_next = S_G_FIN;
        end else if (!stat.pend_v || stat.out_free) begin
          cmd.op     = DP_G_TAIL;
          state_next = S_G_FIN;
        end
      end
      S_G_FIN: begin
        if (stat.out_free) begin
          cmd.op     = DP_G_FIN;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end
endmodule

@@ rtl/boot_region_allocator_unit.sv @@
// Boot region allocator top level: stream ports, config port, controller and datapath.
// One item at a time. A reserve runs two page remainders and then moves table entries
// on insertion. Allocations add a page remainder and an overlap scan of the entries
// for each of up to MAX_REGIONS+2 candidates; a gap list walks the entries.
// Reset empties the region table at once (count cleared) and zeroes ram_base/ram_size.
module boot_region_allocator_unit #(
  parameter int MAX_REGIONS = 32,
  parameter int PAGE_BYTES  = 4096
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [0:0]   cfg_index,
  input  logic [63:0]  cfg_data,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [191:0] s_axis_tdata,  // region_base, region_size, alignment
  input  logic [1:0]   s_axis_tuser,  // opcode
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [127:0] m_axis_tdata,  // result_address, result_size
  output logic [1:0]   m_axis_tuser,  // status
  output logic         m_axis_tlast
);
  import bra_pkg::*;

  dp_cmd_t  cmd;
  dp_stat_t stat;

  assign cfg_ready = 1'b1;

  bra_ctrl u_ctrl (
    .clk(clk), .rst(rst),
    .in_valid(s_axis_tvalid), .in_ready(s_axis_tready),
    .stat(stat), .cmd(cmd)
  );

  bra_dp #(.MAX_REGIONS(MAX_REGIONS), .PAGE_BYTES(PAGE_BYTES)) u_dp (
    .clk(clk), .rst(rst), .cmd(cmd), .stat(stat),
    .cfg_valid(cfg_valid), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_data(s_axis_tdata), .in_user(s_axis_tuser),
    .out_valid(m_axis_tvalid), .out_ready(m_axis_tready),
    .out_data(m_axis_tdata), .out_user(m_axis_tuser), .out_last(m_axis_tlast)
  );
endmodule

@@ verif/boot_region_allocator_unit_tb.sv @@
// Self-checking testbench for boot_region_allocator_unit: stream driver, predictor, monitor.
module boot_region_allocator_unit_tb;
  import bra_pkg::*;

  localparam int NREG = 32;
  localparam logic [63:0] PAGE = 64'd4096;
  localparam logic [63:0] ONES = '1;
  localparam int LIMIT = 4000000;
  localparam logic [0:0] REG_RAM_BASE = 1'b0;
  localparam logic [0:0] REG_RAM_SIZE = 1'b1;

  typedef logic [63:0] w64;
  typedef struct {
    logic [1:0] op;
    w64 base;
    w64 size;
    w64 algn;
  } req_t;
  typedef struct {
    w64 addr;
    w64 len;
    logic [1:0] st;
    logic last;
  } res_t;

  logic clk, rst;
  logic cfg_valid, cfg_ready;
  logic [0:0] cfg_index;
  logic [63:0] cfg_data;
  logic s_axis_tvalid, s_axis_tready;
  logic [191:0] s_axis_tdata;
  logic [1:0] s_axis_tuser;
  logic m_axis_tvalid, m_axis_tready;
  logic [127:0] m_axis_tdata;
  logic [1:0] m_axis_tuser;
  logic m_axis_tlast;

  boot_region_allocator_unit dut (.*);

  req_t pending_q[$];
  res_t expected_q[$];
  int errors = 0;
  int cycles = 0;
  bit calm = 0;

  // predictor state
  w64 win_base, win_size;
  w64 reg_start[NREG];
  w64 reg_len[NREG];
  int reg_cnt;

  function automatic w64 sadd(w64 a, w64 b);
    return (a > ONES - b) ? ONES : a + b;
  endfunction

  function automatic w64 pdown(w64 x);
    return x - (x % PAGE);
  endfunction

  function automatic w64 pup(w64 x, output bit ok);
    w64 rem;
    rem = x % PAGE;
    ok = 1;
    if (rem == 0) return x;
    if (x > ONES - (PAGE - rem)) begin
      ok = 0;
      return ONES;
    end
    return x + (PAGE - rem);
  endfunction

  function automatic w64 fix_align(w64 a);
    if (a == 0) return 64'd1;
    for (int i = 63; i >= 0; i--)
      if (a[i]) return w64'(1) << i;
    return 64'd1;
  endfunction

  function automatic w64 rend(int i);
    return sadd(reg_start[i], reg_len[i]);
  endfunction

  function automatic int overlap_idx(w64 b, w64 s);
    w64 e;
    e = b + s;
    for (int i = 0; i < reg_cnt; i++)
      if (b < rend(i) && e > reg_start[i]) return i;
    return -1;
  endfunction

  function automatic bit reserve_range(w64 b, w64 s, output w64 lo, output w64 len);
    w64 hi;
    bit ok;
    int i;
    lo = pdown(b);
    hi = pup(sadd(b, s), ok);
    len = hi - lo;
    if (reg_cnt >= NREG) return 0;
    i = reg_cnt;
    while (i > 0 && reg_start[i-1] > lo) begin
      reg_start[i] = reg_start[i-1];
      reg_len[i] = reg_len[i-1];
      i--;
    end
    reg_start[i] = lo;
    reg_len[i] = len;
    reg_cnt++;
    return 1;
  endfunction

  function automatic bit place_up(w64 size, w64 al, output w64 addr);
    w64 e, c;
    bit ok;
    int r;
    e = sadd(win_base, win_size);
    addr = 0;
    c = pup(win_base, ok);
    if (!ok) return 0;
    for (int it = 0; it <= NREG + 1; it++) begin
      if (c > ONES - (al - 1)) return 0;
      c = (c + (al - 1)) & ~(al - 1);
      if (c > e || size > e - c) return 0;
      r = overlap_idx(c, size);
      if (r < 0) begin
        addr = c;
        return 1;
      end
      c = rend(r);
    end
    return 0;
  endfunction

  function automatic bit place_down(w64 size, w64 al, output w64 addr);
    w64 top, c, rb;
    int r;
    top = pdown(sadd(win_base, win_size));
    addr = 0;
    if (size > top) return 0;
    c = (top - size) & ~(al - 1);
    for (int it = 0; it <= NREG + 1; it++) begin
      if (c < win_base) return 0;
      r = overlap_idx(c, size);
      if (r < 0) begin
        addr = c;
        return 1;
      end
      rb = reg_start[r];
      if (rb < size) return 0;
      c = (rb - size) & ~(al - 1);
    end
    return 0;
  endfunction

  function automatic void add_exp(w64 a, w64 l, logic [1:0] st, logic last);
    res_t r;
    r.addr = a;
    r.len = l;
    r.st = st;
    r.last = last;
    expected_q.push_back(r);
  endfunction

  function automatic void predict(req_t q);
    w64 lo, len, addr, pos, e, rb, re, al;
    res_t gaps[$];
    res_t g;
    bit ok;
    al = fix_align(q.algn);
    case (q.op)
      OP_RESERVE: begin
        ok = reserve_range(q.base, q.size, lo, len);
        add_exp(lo, len, ok ? ST_OK : ST_FULL, 1'b1);
      end
      OP_ALLOC_UP, OP_ALLOC_DOWN: begin
        ok = (q.op == OP_ALLOC_UP) ? place_up(q.size, al, addr) : place_down(q.size, al, addr);
        if (!ok) add_exp(64'd0, q.size, ST_OOM, 1'b1);
        else begin
          ok = reserve_range(addr, q.size, lo, len);
          add_exp(addr, q.size, ok ? ST_OK : ST_FULL, 1'b1);
        end
      end
      default: begin
        pos = win_base;
        e = sadd(win_base, win_size);
        for (int i = 0; i < reg_cnt && pos < e; i++) begin
          rb = reg_start[i];
          re = rend(i);
          if (rb < pos) begin
            if (re > pos) pos = re;
            continue;
          end
          if (rb > pos) begin
            g.addr = pos;
            g.len = ((rb < e) ? rb : e) - pos;
            g.st = ST_OK;
            g.last = 0;
            gaps.push_back(g);
          end
          pos = re;
        end
        if (pos < e) begin
          g.addr = pos;
          g.len = e - pos;
          g.st = ST_OK;
          g.last = 0;
          gaps.push_back(g);
        end
        if (gaps.size() == 0) add_exp(64'd0, 64'd0, ST_OK, 1'b1);
        foreach (gaps[i]) add_exp(gaps[i].addr, gaps[i].len, ST_OK, i == gaps.size() - 1);
      end
    endcase
  endfunction

  task automatic report_mismatch(string what);
    $display("mismatch at cycle %0d: %s", cycles, what);
    errors++;
  endtask

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // driver
  always @(posedge clk) begin
    req_t q;
    if (rst) begin
      s_axis_tvalid <= 0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        q.op = s_axis_tuser;
        q.base = s_axis_tdata[63:0];
        q.size = s_axis_tdata[127:64];
        q.algn = s_axis_tdata[191:128];
        predict(q);
      end
      if (!s_axis_tvalid || s_axis_tready) begin
        if (pending_q.size() > 0 && (calm || $urandom_range(99) >= 26)) begin
          q = pending_q.pop_front();
          s_axis_tvalid <= 1;
          s_axis_tuser <= q.op;
          s_axis_tdata <= {q.algn, q.size, q.base};
        end else begin
          s_axis_tvalid <= 0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    res_t x;
    if (rst) begin
      m_axis_tready <= 0;
    end else begin
      m_axis_tready <= calm || $urandom_range(99) >= 26;
      if (m_axis_tvalid && m_axis_tready) begin
        if (expected_q.size() == 0) begin
          report_mismatch("result item with nothing expected");
        end else begin
          x = expected_q.pop_front();
          if (m_axis_tdata[63:0] !== x.addr)
            report_mismatch($sformatf("address %h, want %h", m_axis_tdata[63:0], x.addr));
          if (m_axis_tdata[127:64] !== x.len)
            report_mismatch($sformatf("size %h, want %h", m_axis_tdata[127:64], x.len));
          if (m_axis_tuser !== x.st)
            report_mismatch($sformatf("status %0d, want %0d", m_axis_tuser, x.st));
          if (m_axis_tlast !== x.last)
            report_mismatch($sformatf("last %0b, want %0b", m_axis_tlast, x.last));
        end
      end
    end
  end

  function automatic w64 rnd64();
    return {$urandom, $urandom};
  endfunction

  task automatic push_req(logic [1:0] op, w64 b, w64 s, w64 a);
    req_t q;
    q.op = op;
    q.base = b;
    q.size = s;
    q.algn = a;
    pending_q.push_back(q);
  endtask

  task automatic push_random(int n);
    w64 b, s, a;
    logic [1:0] op;
    for (int i = 0; i < n; i++) begin
      op = 2'($urandom_range(3));
      if ($urandom_range(9) == 0) b = rnd64();
      else b = win_base + (w64'($urandom) % ((win_size == 0) ? 64'd1 : win_size));
      case ($urandom_range(9))
        0: s = rnd64();
        1: s = 0;
        2: s = w64'($urandom_range(8191));
        default: s = w64'($urandom_range(16)) * PAGE;
      endcase
      case ($urandom_range(9))
        0: a = rnd64();
        1: a = 0;
        2: a = w64'(1) << 63;
        default: a = w64'(1) << $urandom_range(20);
      endcase
      push_req(op, b, s, a);
    end
  endtask

  task automatic cfg_write(logic [0:0] idx, w64 val);
    @(posedge clk);
    cfg_valid <= 1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 0;
    if (idx == REG_RAM_BASE) win_base = val;
    else win_size = val;
  endtask

  task automatic drain();
    while (pending_q.size() > 0 || s_axis_tvalid || expected_q.size() > 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  initial begin
    win_base = 0;
    win_size = 0;
    reg_cnt = 0;
    rst = 1;
    cfg_valid = 0;
    cfg_index = 0;
    cfg_data = 0;
    repeat (6) @(posedge clk);
    rst <= 0;

    // empty window straight after reset
    push_req(OP_GAPS, 0, 0, 1);
    push_req(OP_ALLOC_UP, 0, 64'h1000, 1);
    drain();

    cfg_write(REG_RAM_BASE, 64'h8000_0000);
    cfg_write(REG_RAM_SIZE, 64'h0400_0000);
    push_req(OP_GAPS, 0, 0, 1);
    push_req(OP_RESERVE, 64'h8000_0800, 64'h1000, 1);
    push_req(OP_RESERVE, ONES, ONES, 1);
    push_req(OP_RESERVE, 0, 0, 1);
    push_req(OP_ALLOC_UP, 0, 64'h3000, 0);
    push_req(OP_ALLOC_UP, 0, 64'h2000, 64'h3);
    push_req(OP_ALLOC_UP, 0, 64'h1000, 64'h8000_0000_0000_0000);
    push_req(OP_ALLOC_UP, 0, 0, 64'h1000);
    push_req(OP_ALLOC_UP, 0, ONES, 1);
    push_req(OP_ALLOC_DOWN, 0, 64'h5000, 64'h10000);
    push_req(OP_ALLOC_DOWN, 0, ONES, 1);
    push_req(OP_ALLOC_DOWN, 0, 0, ONES);
    push_req(OP_RESERVE, 64'h8000_1000, 64'h4000, 1);
    push_req(OP_GAPS, ONES, ONES, ONES);
    drain();

    push_random(40);
    drain();

    cfg_write(REG_RAM_BASE, ONES - 64'h1_0000);
    cfg_write(REG_RAM_SIZE, ONES);
    push_random(20);
    drain();

    calm = 1;
    cfg_write(REG_RAM_BASE, 0);
    push_random(30);
    drain();
    calm = 0;

    cfg_write(REG_RAM_BASE, 64'h1234);
    cfg_write(REG_RAM_SIZE, 64'h2_0000);
    push_random(25);
    drain();
    repeat (200) @(posedge clk);

    if (errors == 0 && expected_q.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

@@ files.f @@
rtl/bra_pkg.sv
rtl/bra_rem.sv
rtl/bra_dp.sv
rtl/bra_ctrl.sv
rtl/boot_region_allocator_unit.sv
verif/boot_region_allocator_unit_tb.sv
